[design/rltm_pkg.sv]
// ----------------------------------------------------------------------------
// rltm_pkg
// Shared constants, request and status codes and the sequencer state type of
// the redundant lane timestamp merge core.
// ----------------------------------------------------------------------------
package rltm_pkg;

    localparam int LANES_DEF        = 2;
    localparam int QUEUE_DEPTH_DEF  = 1024;
    localparam int UPDATE_WIDTH_DEF = 64;

    localparam int REQ_W     = 2;
    localparam int LANE_F_W  = 3;
    localparam int TIME_W    = 63;
    localparam int UPD_F_W   = 64;
    localparam int STATUS_W  = 3;
    localparam int DIS_W     = 8;

    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = STATUS_W + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_FAULT = 2'd1,
        REQ_POP   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_PUSHED  = 3'd0,
        STAT_IGNORED = 3'd1,
        STAT_DROPPED = 3'd2,
        STAT_FAULTED = 3'd3,
        STAT_POPPED  = 3'd4,
        STAT_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_SELECT,
        S_RESOLVE,
        S_FINISH
    } state_t;

endpackage

[design/redundant_lane_timestamp_merge_core.sv]
// ----------------------------------------------------------------------------
// redundant_lane_timestamp_merge_core
// Merges redundant feed lanes: per-lane FIFOs of timestamped updates held in
// one shared memory, a head register per lane, earliest-first selection.
//
// The slave stream carries requests: tuser is the request kind (push, fault,
// pop) and tdata holds the lane, the receive time and the update. Every
// request produces exactly one transfer on the master stream, whose tuser is
// the status and the pop-valid flag and whose tdata holds the returned lane,
// time and update and the mask of disabled lanes after the request.
// Requests are handled one at a time. A push, fault or unknown request is
// resolved in the execute state and written to the result register; a pop
// first refills empty heads one lane at a time through the single read port of
// the FIFO memory, waits in a drain state for the last read, then compares the
// head times lane by lane for the earliest. The next request is accepted only
// after the result has moved into the output register.
// The result sits in an output register; the next request is accepted while
// it waits, and the block stalls only when a further result is ready and the
// receiver still holds tready low. Reset empties every FIFO and head, enables
// every lane and needs no clearing of the FIFO memory.
// ----------------------------------------------------------------------------
module redundant_lane_timestamp_merge_core #(
    parameter int LANES        = rltm_pkg::LANES_DEF,
    parameter int QUEUE_DEPTH  = rltm_pkg::QUEUE_DEPTH_DEF,
    parameter int UPDATE_WIDTH = rltm_pkg::UPDATE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // lane, receive_time, update_word, zero padding
    input  logic [rltm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [rltm_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_lane, out_time, out_update, disabled_lanes, zero padding
    output logic [rltm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status, pop_valid
    output logic [rltm_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import rltm_pkg::*;

    localparam int LANE_W    = $clog2(LANES);
    localparam int PTR_W     = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = LANE_W + PTR_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int ENTRY_W   = TIME_W + UPDATE_WIDTH;
    localparam int PAD_W     = M_TDATA_W - LANE_F_W - TIME_W - UPD_F_W - DIS_W;

    localparam logic [LANE_F_W:0] LANE_LIMIT = (LANE_F_W + 1)'(LANES);
    localparam logic [LANE_W-1:0] LAST_LANE  = LANE_W'(LANES - 1);
    localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    logic [REQ_W-1:0]        req_reg, req_next;
    logic [LANE_F_W-1:0]     lane_reg, lane_next;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic [UPDATE_WIDTH-1:0] upd_reg, upd_next;

    logic [PTR_W-1:0]        wr_ptr_reg [LANES];
    logic [PTR_W-1:0]        wr_ptr_next [LANES];
    logic [PTR_W-1:0]        rd_ptr_reg [LANES];
    logic [PTR_W-1:0]        rd_ptr_next [LANES];
    logic [CNT_W-1:0]        fill_reg [LANES];
    logic [CNT_W-1:0]        fill_next [LANES];
    logic [TIME_W-1:0]       head_time_reg [LANES];
    logic [TIME_W-1:0]       head_time_next [LANES];
    logic [UPDATE_WIDTH-1:0] head_upd_reg [LANES];
    logic [UPDATE_WIDTH-1:0] head_upd_next [LANES];
    logic [LANES-1:0]        head_full_reg, head_full_next;
    logic [LANES-1:0]        dis_reg, dis_next;

    logic [LANE_W-1:0]       scan_reg, scan_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [LANE_W-1:0]       rd_lane_reg, rd_lane_next;
    logic                    best_any_reg, best_any_next;
    logic [LANE_W-1:0]       best_lane_reg, best_lane_next;
    logic [TIME_W-1:0]       best_time_reg, best_time_next;

    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                    res_valid_reg, res_valid_next;
    logic [LANE_F_W-1:0]     res_lane_reg, res_lane_next;
    logic [TIME_W-1:0]       res_time_reg, res_time_next;
    logic [UPDATE_WIDTH-1:0] res_upd_reg, res_upd_next;

    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0]    m_user_reg, m_user_next;

    logic [ENTRY_W-1:0]      mem [MEM_DEPTH];
    logic [ENTRY_W-1:0]      mem_rdata_reg;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;

    logic                    in_take, out_load, out_free;
    logic                    lane_ok;
    logic [LANE_W-1:0]       lane_idx;

    assign lane_ok  = {1'b0, lane_reg} < LANE_LIMIT;
    assign lane_idx = lane_reg[LANE_W-1:0];
    assign out_free = !m_valid_reg || m_axis_tready;
    assign in_take  = s_axis_tvalid && s_axis_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (req_reg == REQ_POP) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN: begin
                if (scan_reg == LAST_LANE) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_SELECT;
            end
            S_SELECT: begin
                if (scan_reg == LAST_LANE) begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_EXEC: begin
                mem_we = (req_reg == REQ_PUSH) && lane_ok && !dis_reg[lane_idx]
                         && (fill_reg[lane_idx] != FULL_CNT);
            end
            S_SCAN: begin
                mem_re = !head_full_reg[scan_reg] && !dis_reg[scan_reg]
                         && (fill_reg[scan_reg] != '0);
            end
            S_FINISH: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign mem_waddr = {lane_idx, wr_ptr_reg[lane_idx]};
    assign mem_raddr = {scan_reg, rd_ptr_reg[scan_reg]};

    // Datapath next values.
    always_comb begin
        req_next        = req_reg;
        lane_next       = lane_reg;
        time_next       = time_reg;
        upd_next        = upd_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        fill_next       = fill_reg;
        head_time_next  = head_time_reg;
        head_upd_next   = head_upd_reg;
        head_full_next  = head_full_reg;
        dis_next        = dis_reg;
        scan_next       = scan_reg;
        rd_pend_next    = 1'b0;
        rd_lane_next    = rd_lane_reg;
        best_any_next   = best_any_reg;
        best_lane_next  = best_lane_reg;
        best_time_next  = best_time_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_lane_next   = res_lane_reg;
        res_time_next   = res_time_reg;
        res_upd_next    = res_upd_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        // A refill read issued in the previous cycle lands in its head.
        if (rd_pend_reg) begin
            head_time_next[rd_lane_reg] = mem_rdata_reg[TIME_W-1:0];
            head_upd_next[rd_lane_reg]  = mem_rdata_reg[ENTRY_W-1:TIME_W];
            head_full_next[rd_lane_reg] = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    req_next  = s_axis_tuser;
                    lane_next = s_axis_tdata[LANE_F_W-1:0];
                    time_next = s_axis_tdata[LANE_F_W +: TIME_W];
                    upd_next  = s_axis_tdata[LANE_F_W + TIME_W +: UPDATE_WIDTH];
                end
            end
            S_EXEC: begin
                res_valid_next = 1'b0;
                res_lane_next  = '0;
                res_time_next  = '0;
                res_upd_next   = '0;
                scan_next      = '0;
                case (req_reg)
                    REQ_PUSH: begin
                        if (!lane_ok || dis_reg[lane_idx]) begin
                            res_status_next = STAT_IGNORED;
                        end else if (fill_reg[lane_idx] == FULL_CNT) begin
                            dis_next[lane_idx] = 1'b1;
                            res_status_next    = STAT_DROPPED;
                        end else begin
                            wr_ptr_next[lane_idx] = (wr_ptr_reg[lane_idx] == LAST_PTR) ?
                                                    '0 : wr_ptr_reg[lane_idx] + 1'b1;
                            fill_next[lane_idx]   = fill_reg[lane_idx] + 1'b1;
                            res_status_next       = STAT_PUSHED;
                        end
                    end
                    REQ_FAULT: begin
                        if (lane_ok) begin
                            dis_next[lane_idx] = 1'b1;
                        end
                        res_status_next = STAT_FAULTED;
                    end
                    default: begin
                        res_status_next = STAT_EMPTY;
                    end
                endcase
            end
            S_SCAN: begin
                if (!head_full_reg[scan_reg]) begin
                    if (dis_reg[scan_reg]) begin
                        rd_ptr_next[scan_reg] = wr_ptr_reg[scan_reg];
                        fill_next[scan_reg]   = '0;
                    end else if (fill_reg[scan_reg] != '0) begin
                        rd_ptr_next[scan_reg] = (rd_ptr_reg[scan_reg] == LAST_PTR) ?
                                                '0 : rd_ptr_reg[scan_reg] + 1'b1;
                        fill_next[scan_reg]   = fill_reg[scan_reg] - 1'b1;
                        rd_pend_next          = 1'b1;
                        rd_lane_next          = scan_reg;
                    end
                end
                if (scan_reg != LAST_LANE) begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                scan_next     = '0;
                best_any_next = 1'b0;
            end
            S_SELECT: begin
                if (head_full_reg[scan_reg]
                    && (!best_any_reg || (head_time_reg[scan_reg] < best_time_reg))) begin
                    best_any_next  = 1'b1;
                    best_lane_next = scan_reg;
                    best_time_next = head_time_reg[scan_reg];
                end
                if (scan_reg != LAST_LANE) begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_RESOLVE: begin
                if (best_any_reg) begin
                    head_full_next[best_lane_reg] = 1'b0;
                    res_status_next = STAT_POPPED;
                    res_valid_next  = 1'b1;
                    res_lane_next   = LANE_F_W'(best_lane_reg);
                    res_time_next   = best_time_reg;
                    res_upd_next    = head_upd_reg[best_lane_reg];
                end else begin
                    res_status_next = STAT_EMPTY;
                end
            end
            default: begin
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {{PAD_W{1'b0}}, DIS_W'(dis_reg), UPD_F_W'(res_upd_reg),
                            res_time_reg, res_lane_reg};
            m_user_next  = {res_valid_reg, res_status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= {upd_reg, time_reg};
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_full_reg <= '0;
            dis_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
        end else begin
            state_reg     <= state_next;
            head_full_reg <= head_full_next;
            dis_reg       <= dis_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        lane_reg       <= lane_next;
        time_reg       <= time_next;
        upd_reg        <= upd_next;
        head_time_reg  <= head_time_next;
        head_upd_reg   <= head_upd_next;
        scan_reg       <= scan_next;
        rd_lane_reg    <= rd_lane_next;
        best_any_reg   <= best_any_next;
        best_lane_reg  <= best_lane_next;
        best_time_reg  <= best_time_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_lane_reg   <= res_lane_next;
        res_time_reg   <= res_time_next;
        res_upd_reg    <= res_upd_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

[tb/redundant_lane_timestamp_merge_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// redundant_lane_timestamp_merge_core_test
// Self-checking testbench for the lane merge core. A driver sends push, fault,
// pop and unknown requests from a queue and predicts every result with its
// own model of the lane FIFOs, heads and disabled mask. A monitor compares
// each result transfer field by field. Both sides pause at random. The run
// covers directed corner cases, a balanced random phase and a closing
// phase that overflows one lane and faults the other.
// ----------------------------------------------------------------------------
module redundant_lane_timestamp_merge_core_test;
    import rltm_pkg::*;

    localparam int NUM_LANES      = LANES_DEF;
    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [62:0] TIME_MAX = {63{1'b1}};

    typedef struct {
        req_t        req;
        logic [2:0]  lane;
        logic [62:0] rtime;
        logic [63:0] word;
    } lane_request_t;

    typedef struct {
        status_t     status;
        logic        pop_valid;
        logic [2:0]  lane;
        logic [62:0] rtime;
        logic [63:0] word;
        logic [7:0]  disabled;
    } merge_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    redundant_lane_timestamp_merge_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted lane state.
    logic [63:0] lane_fifo_word [NUM_LANES][DEPTH];
    logic [62:0] lane_fifo_time [NUM_LANES][DEPTH];
    int          lane_wr_ptr [NUM_LANES];
    int          lane_rd_ptr [NUM_LANES];
    int          lane_fill   [NUM_LANES];
    logic [63:0] lane_head_word [NUM_LANES];
    logic [62:0] lane_head_time [NUM_LANES];
    bit          lane_head_full [NUM_LANES];
    bit          lane_dead      [NUM_LANES];

    // Both queues are filled at the front and drained from the back.
    lane_request_t pending_requests[$];
    merge_result_t awaited_results[$];
    lane_request_t cur_request;
    int            request_total = 0;
    int            accepted_requests = 0;
    int            mismatch_count = 0;
    int            send_wait = 0;
    int            recv_wait = 0;
    int            idle_cycles = 0;
    bit            send_steady = 1'b0;
    bit            recv_steady = 1'b0;

    function automatic merge_result_t merge_outcome(input lane_request_t r);
        merge_result_t res;
        int  l;
        int  sel;
        bit  found;
        bit  have;
        res.status    = STAT_EMPTY;
        res.pop_valid = 1'b0;
        res.lane      = '0;
        res.rtime     = '0;
        res.word      = '0;
        res.disabled  = '0;
        sel   = 0;
        found = 1'b0;
        case (r.req)
            REQ_PUSH: begin
                if (r.lane >= NUM_LANES || lane_dead[r.lane]) begin
                    res.status = STAT_IGNORED;
                end else if (lane_fill[r.lane] >= DEPTH) begin
                    lane_dead[r.lane] = 1'b1;
                    res.status = STAT_DROPPED;
                end else begin
                    lane_fifo_word[r.lane][lane_wr_ptr[r.lane]] = r.word;
                    lane_fifo_time[r.lane][lane_wr_ptr[r.lane]] = r.rtime;
                    lane_wr_ptr[r.lane] = (lane_wr_ptr[r.lane] + 1) % DEPTH;
                    lane_fill[r.lane]++;
                    res.status = STAT_PUSHED;
                end
            end
            REQ_FAULT: begin
                if (r.lane < NUM_LANES) begin
                    lane_dead[r.lane] = 1'b1;
                end
                res.status = STAT_FAULTED;
            end
            REQ_POP: begin
                for (l = 0; l < NUM_LANES; l++) begin
                    have = lane_head_full[l];
                    if (!have) begin
                        if (lane_dead[l]) begin
                            lane_rd_ptr[l] = lane_wr_ptr[l];
                            lane_fill[l] = 0;
                        end else if (lane_fill[l] != 0) begin
                            lane_head_word[l] = lane_fifo_word[l][lane_rd_ptr[l]];
                            lane_head_time[l] = lane_fifo_time[l][lane_rd_ptr[l]];
                            lane_rd_ptr[l] = (lane_rd_ptr[l] + 1) % DEPTH;
                            lane_fill[l]--;
                            lane_head_full[l] = 1'b1;
                            have = 1'b1;
                        end
                    end
                    if (have && (!found || lane_head_time[l] < lane_head_time[sel])) begin
                        sel = l;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    lane_head_full[sel] = 1'b0;
                    res.status    = STAT_POPPED;
                    res.pop_valid = 1'b1;
                    res.lane      = sel[2:0];
                    res.rtime     = lane_head_time[sel];
                    res.word      = lane_head_word[sel];
                end
            end
            default: begin
                res.status = STAT_EMPTY;
            end
        endcase
        for (l = 0; l < NUM_LANES; l++) begin
            res.disabled[l] = lane_dead[l];
        end
        return res;
    endfunction

    function automatic logic [62:0] random_time();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return 63'({$urandom, $urandom});
        end else if (pick < 8) begin
            return 63'($urandom_range(0, 15));
        end else if (pick == 8) begin
            return TIME_MAX - 63'($urandom_range(0, 3));
        end
        return '0;
    endfunction

    function automatic lane_request_t random_request();
        lane_request_t r;
        int pick;
        pick    = $urandom_range(0, 99);
        r.lane  = 3'($urandom_range(0, 7));
        r.rtime = random_time();
        r.word  = {$urandom, $urandom};
        if (pick < 50) begin
            r.req = REQ_PUSH;
            if ($urandom_range(0, 19) != 0) begin
                r.lane = 3'($urandom_range(0, NUM_LANES - 1));
            end
        end else if (pick < 93) begin
            r.req = REQ_POP;
        end else if (pick < 96) begin
            r.req  = REQ_FAULT;
            r.lane = 3'($urandom_range(NUM_LANES, 7));
        end else begin
            r.req = REQ_NONE;
        end
        return r;
    endfunction

    task automatic add_request(input req_t req, input logic [2:0] lane,
                               input logic [62:0] rtime, input logic [63:0] word);
        lane_request_t r;
        r.req   = req;
        r.lane  = lane;
        r.rtime = rtime;
        r.word  = word;
        pending_requests.push_front(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    function automatic int draw_pause(input bit steady);
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    // Driver.
    always @(posedge aclk) begin
        bit hold;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_wait <= 0;
        end else begin
            hold = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_front(merge_outcome(cur_request));
                accepted_requests++;
            end
            if ($urandom_range(0, 39) == 0) begin
                send_steady <= ~send_steady;
            end
            if (!hold) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_request = pending_requests.pop_back();
                    s_axis_tdata <= {6'b0, cur_request.word, cur_request.rtime,
                                     cur_request.lane};
                    s_axis_tuser <= cur_request.req;
                    s_axis_tvalid <= 1'b1;
                    send_wait <= draw_pause(send_steady);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        merge_result_t want;
        int pause;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if ($urandom_range(0, 39) == 0) begin
                recv_steady <= ~recv_steady;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_back();
                    check_field("status", 64'(want.status), 64'(m_axis_tuser[2:0]));
                    check_field("pop_valid", 64'(want.pop_valid), 64'(m_axis_tuser[3]));
                    check_field("out_lane", 64'(want.lane), 64'(m_axis_tdata[2:0]));
                    check_field("out_time", 64'(want.rtime), 64'(m_axis_tdata[65:3]));
                    check_field("out_update", want.word, m_axis_tdata[129:66]);
                    check_field("disabled_lanes", 64'(want.disabled),
                                64'(m_axis_tdata[137:130]));
                end
                pause = draw_pause(recv_steady);
                recv_wait <= pause;
                m_axis_tready <= (pause == 0);
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                m_axis_tready <= (recv_wait == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int l = 0; l < NUM_LANES; l++) begin
            lane_wr_ptr[l] = 0;
            lane_rd_ptr[l] = 0;
            lane_fill[l] = 0;
            lane_head_full[l] = 1'b0;
            lane_dead[l] = 1'b0;
        end

        // Directed corner cases: empty pop, extreme values, ordering and ties.
        add_request(REQ_POP,   3'd0, '0, '0);
        add_request(REQ_NONE,  3'd7, TIME_MAX, '1);
        add_request(REQ_PUSH,  3'd0, TIME_MAX, '1);
        add_request(REQ_PUSH,  3'd1, '0, '0);
        add_request(REQ_PUSH,  3'd0, 63'd7, 64'h5555_5555_5555_5555);
        add_request(REQ_PUSH,  3'd1, 63'd7, 64'hAAAA_AAAA_AAAA_AAAA);
        add_request(REQ_POP,   3'd7, TIME_MAX, '1);
        add_request(REQ_POP,   3'd0, '0, '0);
        add_request(REQ_POP,   3'd0, '0, '0);
        add_request(REQ_POP,   3'd0, '0, '0);
        add_request(REQ_PUSH,  3'd0, 63'd100, 64'h0123_4567_89AB_CDEF);
        add_request(REQ_PUSH,  3'd1, 63'd100, 64'hFEDC_BA98_7654_3210);
        add_request(REQ_POP,   3'd0, '0, '0);
        add_request(REQ_POP,   3'd0, '0, '0);
        add_request(REQ_POP,   3'd0, '0, '0);
        add_request(REQ_PUSH,  3'd2, 63'd1, 64'd1);
        add_request(REQ_PUSH,  3'd7, TIME_MAX, '1);
        add_request(REQ_FAULT, 3'd4, '0, '0);
        add_request(REQ_FAULT, 3'd7, TIME_MAX, '1);
        add_request(REQ_NONE,  3'd0, '0, '0);
        add_request(REQ_POP,   3'd0, '0, '0);

        repeat (240) begin
            pending_requests.push_front(random_request());
        end

        // Overflow lane 1, then fault lane 0 while heads may still be held.
        add_request(REQ_PUSH, 3'd0, 63'd50, {$urandom, $urandom});
        repeat (DEPTH + 6) begin
            add_request(REQ_PUSH, 3'd1, random_time(), {$urandom, $urandom});
        end
        add_request(REQ_POP,   3'd0, '0, '0);
        add_request(REQ_FAULT, 3'd0, '0, '0);
        add_request(REQ_FAULT, 3'd0, '0, '0);
        add_request(REQ_PUSH,  3'd0, 63'd3, 64'd3);
        add_request(REQ_PUSH,  3'd1, 63'd3, 64'd3);
        repeat (4) begin
            add_request(REQ_POP, 3'($urandom_range(0, 7)), random_time(), '0);
        end
        add_request(REQ_NONE,  3'd5, 63'd9, 64'd9);
        add_request(REQ_FAULT, 3'd1, '0, '0);
        add_request(REQ_POP,   3'd0, '0, '0);

        request_total = pending_requests.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_requests < request_total || awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
